// ----- src/selective_repeat_sender_window_macros.svh -----
// Assertion macros shared by the selective-repeat sender window RTL.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH

`ifndef ASSERT_OFF
// expr must hold at every clock edge outside reset
`define SRSW_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
// when ante holds, cons must hold in the same cycle
`define SRSW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// when ante holds, cons must hold in the next cycle
`define SRSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SRSW_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define SRSW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define SRSW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/srsw_pkg.sv -----
// Types, codes and defaults for the selective-repeat sender window.
package srsw_pkg;

	// parameter defaults
	localparam int DEF_WINDOW       = 8;
	localparam int DEF_SEQ_BITS     = 8;
	localparam int DEF_PAYLOAD_BITS = 64;

	// fixed port field widths
	localparam int PAY_W    = 64;
	localparam int SEQ_W    = 8;
	localparam int WIU_W    = 4;
	localparam logic [WIU_W-1:0] WIU_RESET = 4'd4;

	// command codes
	localparam logic [1:0] CMD_SEND    = 2'd0;
	localparam logic [1:0] CMD_ACK     = 2'd1;
	localparam logic [1:0] CMD_TIMEOUT = 2'd2;

	// status codes
	localparam logic [2:0] ST_SENT    = 3'd0;
	localparam logic [2:0] ST_REFUSED = 3'd1;
	localparam logic [2:0] ST_ACK_OK  = 3'd2;
	localparam logic [2:0] ST_ACK_IGN = 3'd3;
	localparam logic [2:0] ST_RESENT  = 3'd4;
	localparam logic [2:0] ST_TO_IGN  = 3'd5;

	// timer actions
	localparam logic [1:0] TMR_NONE    = 2'd0;
	localparam logic [1:0] TMR_START   = 2'd1;
	localparam logic [1:0] TMR_STOP    = 2'd2;
	localparam logic [1:0] TMR_RESTART = 2'd3;

	typedef struct packed {
		logic [1:0]       command;
		logic [PAY_W-1:0] payload;
		logic [SEQ_W-1:0] target_seq;
		logic             checksum_ok;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [SEQ_W-1:0] seq_number;
		logic [PAY_W-1:0] packet_payload;
		logic [1:0]       timer_action;
		logic [SEQ_W-1:0] window_base;
		logic             window_full;
	} rsp_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic shift;
		logic load;
		logic mark;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_SLIDE
	} fsm_t;

endpackage

// ----- src/selective_repeat_sender_window.sv -----
// Top level: selective-repeat ARQ sender window built as a row of slot cells.
//
// Usage:
//  - Command channel: request is taken at a clock edge with start high and
//    busy low. command 0 sends payload, 1 reports an ack for target_seq,
//    2 reports a timer expiry for target_seq.
//  - Result channel: one result per command, shown on result for exactly one
//    cycle while done is high. The receiver cannot stall it.
//  - Config: cfg_we writes cfg_wdata into the window size register (0 acts as
//    1, clamped to the cell count); write only while the block is idle.
//  - Sequence: the accept edge moves the block to EXEC, and done is registered
//    from EXEC for send, timeout and acks that do not hit the window base. An
//    ack at the base goes on to SLIDE, where the window slides while it is not
//    empty and its base slot is confirmed; done is registered when it stops.
//  - Overlap: no new command is taken while busy; the next command may be taken
//    in the cycle done is high. The slide is bound by the cell row moving
//    one slot per cycle.
//  - Reset: window empty, base and next sequence zero, window size 4.
`include "selective_repeat_sender_window_macros.svh"

module selective_repeat_sender_window #(
	parameter int WINDOW       = srsw_pkg::DEF_WINDOW,
	parameter int SEQ_BITS     = srsw_pkg::DEF_SEQ_BITS,
	parameter int PAYLOAD_BITS = srsw_pkg::DEF_PAYLOAD_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  srsw_pkg::req_t              request,
	output logic                        done,
	output srsw_pkg::rsp_t              result,
	input  logic                        cfg_we,
	input  logic [srsw_pkg::WIU_W-1:0]  cfg_wdata
);

	localparam int HALF  = 1 << (SEQ_BITS - 1);
	localparam int NCELL = (WINDOW < HALF) ? WINDOW : HALF;
	localparam logic [SEQ_BITS-1:0] LIM = SEQ_BITS'(NCELL);
	localparam logic [SEQ_BITS-1:0] ONE = SEQ_BITS'(1);

	srsw_pkg::fsm_t state_q, state_d;

	logic [srsw_pkg::WIU_W-1:0] wiu_q;
	logic [SEQ_BITS-1:0]        base_q, next_q;
	logic                       done_q;
	srsw_pkg::rsp_t             res_q;

	// captured command
	logic [1:0]              cmd_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [SEQ_BITS-1:0]     tgt_q;
	logic                    ck_q;

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != srsw_pkg::FSM_IDLE);

	// cell row, with a zero neighbor past the last cell
	srsw_pkg::cell_ctrl_t    ctrl [NCELL];
	logic                    conf [NCELL+1];
	logic [PAYLOAD_BITS-1:0] pay  [NCELL+1];

	assign conf[NCELL] = 1'b0;
	assign pay[NCELL]  = '0;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		srsw_cell #(
			.PAYLOAD_BITS(PAYLOAD_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl[k]),
			.wdata    (pay_q),
			.nbr_conf (conf[k+1]),
			.nbr_pay  (pay[k+1]),
			.conf     (conf[k]),
			.pay      (pay[k])
		);
	end

	// window occupancy and effective size
	logic [SEQ_BITS-1:0] outst, off, eff, wiu_ext, outst_new;
	logic                full_now, full_after, in_win;

	assign outst   = next_q - base_q;
	assign off     = tgt_q - base_q;
	assign in_win  = (off < outst);
	assign wiu_ext = SEQ_BITS'(wiu_q);
	assign eff     = (wiu_ext == '0) ? ONE : ((wiu_ext > LIM) ? LIM : wiu_ext);
	assign full_now = (outst >= eff);

	// slot selected by target offset
	logic                    conf_sel;
	logic [PAYLOAD_BITS-1:0] pay_sel;

	always_comb begin
		conf_sel = 1'b0;
		pay_sel  = '0;
		for (int k = 0; k < NCELL; k++) begin
			if (SEQ_BITS'(k) == off) begin
				conf_sel = conf[k];
				pay_sel  = pay[k];
			end
		end
	end

	// command decision
	logic [2:0]              st_d;
	logic [SEQ_BITS-1:0]     seq_d;
	logic [PAYLOAD_BITS-1:0] opay_d;
	logic [1:0]              tmr_d;
	logic                    send_ok, ack_ok, go_slide;

	always_comb begin
		st_d     = srsw_pkg::ST_TO_IGN;
		seq_d    = tgt_q;
		opay_d   = '0;
		tmr_d    = srsw_pkg::TMR_NONE;
		send_ok  = 1'b0;
		ack_ok   = 1'b0;
		go_slide = 1'b0;
		case (cmd_q)
			srsw_pkg::CMD_SEND: begin
				seq_d = next_q;
				if (full_now) begin
					st_d = srsw_pkg::ST_REFUSED;
				end else begin
					st_d    = srsw_pkg::ST_SENT;
					opay_d  = pay_q;
					tmr_d   = srsw_pkg::TMR_START;
					send_ok = 1'b1;
				end
			end
			srsw_pkg::CMD_ACK: begin
				if (ck_q && in_win) begin
					st_d     = srsw_pkg::ST_ACK_OK;
					tmr_d    = srsw_pkg::TMR_STOP;
					ack_ok   = 1'b1;
					go_slide = (off == '0);
				end else begin
					st_d = srsw_pkg::ST_ACK_IGN;
				end
			end
			srsw_pkg::CMD_TIMEOUT: begin
				if (in_win && !conf_sel) begin
					st_d   = srsw_pkg::ST_RESENT;
					opay_d = pay_sel;
					tmr_d  = srsw_pkg::TMR_RESTART;
				end
			end
			default: begin
				st_d = srsw_pkg::ST_TO_IGN;
			end
		endcase
	end

	assign outst_new  = send_ok ? (outst + ONE) : outst;
	assign full_after = (outst_new >= eff);

	// slide one slot a cycle while the window is not empty and the base slot is confirmed
	logic shift_en;
	assign shift_en = (state_q == srsw_pkg::FSM_SLIDE) && (outst != '0) && conf[0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			srsw_pkg::FSM_IDLE: begin
				if (accept) begin
					state_d = srsw_pkg::FSM_EXEC;
				end
			end
			srsw_pkg::FSM_EXEC: begin
				state_d = go_slide ? srsw_pkg::FSM_SLIDE : srsw_pkg::FSM_IDLE;
			end
			srsw_pkg::FSM_SLIDE: begin
				if (!shift_en) begin
					state_d = srsw_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = srsw_pkg::FSM_IDLE;
			end
		endcase
	end

	// cell controls
	always_comb begin
		for (int k = 0; k < NCELL; k++) begin
			ctrl[k].shift = shift_en;
			ctrl[k].load  = (state_q == srsw_pkg::FSM_EXEC) && send_ok &&
				(SEQ_BITS'(k) == outst);
			ctrl[k].mark  = (state_q == srsw_pkg::FSM_EXEC) && ack_ok &&
				(SEQ_BITS'(k) == off);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srsw_pkg::FSM_IDLE;
			wiu_q   <= srsw_pkg::WIU_RESET;
			base_q  <= '0;
			next_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				wiu_q <= cfg_wdata;
			end
			if (state_q == srsw_pkg::FSM_EXEC && send_ok) begin
				next_q <= next_q + ONE;
			end
			if (shift_en) begin
				base_q <= base_q + ONE;
			end
			done_q <= ((state_q == srsw_pkg::FSM_EXEC) && !go_slide) ||
				((state_q == srsw_pkg::FSM_SLIDE) && !shift_en);
		end
	end

	// command capture and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= request.command;
			pay_q <= PAYLOAD_BITS'(request.payload);
			tgt_q <= SEQ_BITS'(request.target_seq);
			ck_q  <= request.checksum_ok;
		end
		if (state_q == srsw_pkg::FSM_EXEC) begin
			res_q.status         <= st_d;
			res_q.seq_number     <= srsw_pkg::SEQ_W'(seq_d);
			res_q.packet_payload <= srsw_pkg::PAY_W'(opay_d);
			res_q.timer_action   <= tmr_d;
			res_q.window_base    <= srsw_pkg::SEQ_W'(base_q);
			res_q.window_full    <= full_after;
		end else if (state_q == srsw_pkg::FSM_SLIDE && !shift_en) begin
			res_q.window_base <= srsw_pkg::SEQ_W'(base_q);
			res_q.window_full <= full_now;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	// checks
	`SRSW_ASSERT_ALWAYS(a_outst_bound, clk, arst_n, outst <= LIM)
	`SRSW_ASSERT_IMPLIES(a_head_open, clk, arst_n, (state_q == srsw_pkg::FSM_IDLE) && (outst != '0), !conf[0])
	`SRSW_ASSERT_NEXT(a_slide_step, clk, arst_n, shift_en, base_q == SEQ_BITS'($past(base_q) + ONE))
	`SRSW_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q)
	`SRSW_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, busy && !done_q)

endmodule

// ----- src/srsw_cell.sv -----
// One window slot: confirmed mark and stored payload, shifts toward the base.
module srsw_cell #(
	parameter int PAYLOAD_BITS = srsw_pkg::DEF_PAYLOAD_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  srsw_pkg::cell_ctrl_t    ctrl,
	input  logic [PAYLOAD_BITS-1:0] wdata,
	input  logic                    nbr_conf,
	input  logic [PAYLOAD_BITS-1:0] nbr_pay,
	output logic                    conf,
	output logic [PAYLOAD_BITS-1:0] pay
);

	logic                    conf_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	// confirmed mark: shift beats load beats mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_q <= 1'b0;
		end else if (ctrl.shift) begin
			conf_q <= nbr_conf;
		end else if (ctrl.load) begin
			conf_q <= 1'b0;
		end else if (ctrl.mark) begin
			conf_q <= 1'b1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			pay_q <= nbr_pay;
		end else if (ctrl.load) begin
			pay_q <= wdata;
		end
	end

	assign conf = conf_q;
	assign pay  = pay_q;

endmodule
